/* rtl/core/wsd_pkg.sv */
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SWALLOW = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_CLOSE   = 2'd1,
		KIND_EMPTY   = 2'd2
	} kind_t;

	localparam logic [3:0] OPCODE_MASK  = 4'hF;
	localparam logic [3:0] OPCODE_CLOSE = 4'h8;
	localparam logic [6:0] LEN_MAX7     = 7'd125;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [3:0] EXT16_BYTES  = 4'd2;
	localparam logic [3:0] EXT64_BYTES  = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
		logic [3:0] frame_opcode;
		logic       final_fragment;
		kind_t      result_kind;
	} result_t;

endpackage

/* rtl/core/wsd_parser.sv */
module wsd_parser
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic        mask_q, mask_d;
	logic [3:0]  fbl_q, fbl_d;
	logic [63:0] plen_q, plen_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  mpos_q, mpos_d;

	logic        len_done;
	logic        hdr_done;
	logic [6:0]  len7;
	logic [7:0]  kb;
	logic [63:0] plen_dec;

	// saturating decrement of the remaining payload count
	assign plen_dec = (plen_q != 64'd0) ? plen_q - 64'd1 : plen_q;
	assign len7     = rx_byte[6:0];

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		fin_d     = fin_q;
		mask_d    = mask_q;
		fbl_d     = fbl_q;
		plen_d    = plen_q;
		key_d     = key_q;
		mpos_d    = mpos_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		kb        = 8'd0;
		res_valid = 1'b0;
		res.data_byte      = 8'd0;
		res.end_of_frame   = 1'b1;
		res.frame_opcode   = opcode_q;
		res.final_fragment = fin_q;
		res.result_kind    = KIND_PAYLOAD;

		unique case (phase_q)
			PH_HDR1: begin
				mask_d = rx_byte[7];
				plen_d = 64'd0;
				if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
					fbl_d   = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					if (len7 <= LEN_MAX7)
						plen_d = {57'd0, len7};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				plen_d = {plen_q[55:0], rx_byte};
				if (fbl_q != 4'd0)
					fbl_d = fbl_q - 4'd1;
				len_done = (fbl_d == 4'd0);
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				if (fbl_q != 4'd0)
					fbl_d = fbl_q - 4'd1;
				hdr_done = (fbl_d == 4'd0);
			end
			PH_PAYLOAD: begin
				if (mask_q) begin
					unique case (mpos_q)
						2'd0: kb = key_q[31:24];
						2'd1: kb = key_q[23:16];
						2'd2: kb = key_q[15:8];
						default: kb = key_q[7:0];
					endcase
				end
				mpos_d = mpos_q + 2'd1;
				plen_d = plen_dec;
				if (plen_dec == 64'd0)
					phase_d = PH_HDR0;
				res_valid          = 1'b1;
				res.data_byte      = rx_byte ^ kb;
				res.end_of_frame   = (plen_dec == 64'd0);
				res.result_kind    = KIND_PAYLOAD;
			end
			PH_SWALLOW: begin
				plen_d = plen_dec;
				if (plen_dec == 64'd0)
					phase_d = PH_HDR0;
			end
			default: begin
				fin_d    = rx_byte[7];
				opcode_d = rx_byte[3:0] & OPCODE_MASK;
				phase_d  = PH_HDR1;
			end
		endcase

		// length known: fetch the key or close the header
		if (len_done) begin
			if (mask_d) begin
				fbl_d   = KEY_BYTES;
				key_d   = 32'd0;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		// header complete: restart the key index and decide what follows
		if (hdr_done) begin
			mpos_d = 2'd0;
			if (opcode_q == OPCODE_CLOSE) begin
				phase_d         = (plen_d != 64'd0) ? PH_SWALLOW : PH_HDR0;
				res_valid       = 1'b1;
				res.result_kind = KIND_CLOSE;
			end else if (plen_d == 64'd0) begin
				phase_d         = PH_HDR0;
				res_valid       = 1'b1;
				res.result_kind = KIND_EMPTY;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			fin_q    <= 1'b0;
			mask_q   <= 1'b0;
			fbl_q    <= 4'd0;
			plen_q   <= 64'd0;
			key_q    <= 32'd0;
			mpos_q   <= 2'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			mask_q   <= mask_d;
			fbl_q    <= fbl_d;
			plen_q   <= plen_d;
			key_q    <= key_d;
			mpos_q   <= mpos_d;
		end
	end

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD || phase_q == PH_SWALLOW) |-> plen_q != 64'd0)
		else $error("payload phase entered with zero length left");

	a_last_byte_home: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_PAYLOAD && plen_q == 64'd1) |=> phase_q == PH_HDR0)
		else $error("last payload byte did not return to header");

	a_key_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && hdr_done) |=> mpos_q == 2'd0)
		else $error("mask index not cleared at end of header");

endmodule

/* rtl/core/websocket_frame_deframer.sv */
// WebSocket frame deframer.
// Input channel: one received byte of the frame stream per item on rx_byte,
// handshaked by in_valid / in_ready. Output channel: at most one result item
// per input item, handshaked by out_valid / out_ready, carrying the unmasked
// payload byte, end_of_frame, the frame's opcode and fin bit, and a kind code
// (payload byte, close frame seen, empty data frame).
// Each input byte is captured in an input register, parsed by the header /
// payload state logic once the result register can take its result, and
// written to the result register, which drives out_valid. Bytes that cause
// no result (most header bytes, swallowed close payload) simply retire.
// Throughput is one byte per cycle while the receiver takes results, set by
// the parse step (a 64-bit length decrement and zero test plus a byte XOR).
// When the receiver stalls, the result register holds its item, the parse
// stage holds its byte, and in_ready drops only once both are occupied.
// Reset clears the parse state to "expecting first header byte" and empties
// both stages; no clearing pass is needed.
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       end_of_frame,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic [1:0] result_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	logic       advance;
	logic       res_valid;
	result_t    res;

	// parse the held byte whenever the result register can take its result
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: load on a parse step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = out_q.data_byte;
	assign end_of_frame   = out_q.end_of_frame;
	assign frame_opcode   = out_q.frame_opcode;
	assign final_fragment = out_q.final_fragment;
	assign result_kind    = out_q.result_kind;

	a_event_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind != KIND_PAYLOAD) |->
		(out_q.end_of_frame && out_q.data_byte == 8'd0))
		else $error("event result without end_of_frame or with data");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("parse stage lost its byte while stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("parse step while result register is blocked");

endmodule
